@@ design/clr_pkg.sv @@
// Shared types and constants of the console line reader.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package clr_pkg;

   localparam int AddrWidthDefault  = 32;
   localparam int QueueDepthDefault = 4;

   // request kinds
   localparam logic ReqStart = 1'b0;
   localparam logic ReqChar  = 1'b1;

   // configuration register indexes
   localparam logic CsrMemLow  = 1'b0;
   localparam logic CsrMemHigh = 1'b1;

   localparam logic [31:0] MemLowReset  = 32'hA000_0000;
   localparam logic [31:0] MemHighReset = 32'hA3FF_FFFF;

   localparam logic [15:0] DescConsole = 16'd0;

   // characters
   localparam logic [7:0] ChEot   = 8'd4;
   localparam logic [7:0] ChBs    = 8'd8;
   localparam logic [7:0] ChNl    = 8'd10;
   localparam logic [7:0] ChCr    = 8'd13;
   localparam logic [7:0] ChSpace = 8'd32;
   localparam logic [7:0] ChDel   = 8'd127;

   // completion status
   localparam logic [1:0] StatOk      = 2'd0;
   localparam logic [1:0] StatBadAddr = 2'd1;
   localparam logic [1:0] StatBadDesc = 2'd2;

   // one queued job: a single result, or the backspace-space-backspace triple
   typedef struct packed {
      logic        echo_valid;
      logic [7:0]  echo_char;
      logic        write_valid;
      logic [31:0] write_addr;
      logic [7:0]  write_data;
      logic        done_res;
      logic [31:0] byte_count;
      logic [1:0]  status;
      logic        triple;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

@@ design/console_line_reader.sv @@
// Console line reader: start requests open a checked read, character requests edit it.
// A response passes through the queue (written at the accepting edge) and then the
// response register, loaded when the back end takes the job from the queue.
// Throughput: one request per cycle unless the queue is full; the response register moves
// one per cycle while taken, so the queue absorbs while an erase's three responses drain.
// Reset (synchronous, active high): no read open, queue and response register empty,
// memory window back to its default bounds. Depends on clr_pkg, clr_front/queue/back.
`timescale 1ns / 1ps

module console_line_reader #(
   parameter int ADDR_WIDTH  = clr_pkg::AddrWidthDefault,
   parameter int QUEUE_DEPTH = clr_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [15:0] req_descriptor,
   input  logic [31:0] req_buf_addr,
   input  logic [31:0] req_length,
   input  logic [7:0]  req_char_in,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_echo_valid,
   output logic [7:0]  rsp_echo_char,
   output logic        rsp_write_valid,
   output logic [31:0] rsp_write_addr,
   output logic [7:0]  rsp_write_data,
   output logic        rsp_done_res,
   output logic [31:0] rsp_byte_count,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);
   import clr_pkg::*;

   // front -> queue: one job per request that produces output
   logic      q_push;
   job_type   q_push_data;
   // queue -> back: head job, popped when its final response is loaded into the register
   logic      q_pop;
   job_type   q_head;
   qstat_type q_stat;

   // Front holds the window registers and the open-read state (base, limit,
   // count). It only stalls when the queue is full.
   clr_front #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_descriptor (req_descriptor),
      .req_buf_addr   (req_buf_addr),
      .req_length     (req_length),
      .req_char_in    (req_char_in),
      .q_stat         (q_stat),
      .push           (q_push),
      .push_data      (q_push_data)
   );

   // Decouples request acceptance from response backpressure.
   clr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   // Back expands erase jobs into backspace, space, backspace and owns the
   // response register; it refills the register in the cycle it is taken.
   clr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (q_head),
      .q_stat          (q_stat),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_echo_valid  (rsp_echo_valid),
      .rsp_echo_char   (rsp_echo_char),
      .rsp_write_valid (rsp_write_valid),
      .rsp_write_addr  (rsp_write_addr),
      .rsp_write_data  (rsp_write_data),
      .rsp_done_res    (rsp_done_res),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   // the front must never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("job pushed into full queue");

   // a pop only happens when there is something to pop
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("job popped from empty queue");

   // errors always finish the request in a single response
   a_error_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != StatOk |-> rsp_done_res && rsp_last)
      else $error("error response without done/last");

   // only the first two erase responses lack last, and those never finish or write
   a_mid_triple: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !rsp_done_res && !rsp_write_valid && rsp_echo_valid)
      else $error("bad intermediate erase response");

   // a buffer write is always echoed
   a_write_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_valid |-> rsp_echo_valid)
      else $error("write without echo");

endmodule

@@ design/clr_queue.sv @@
// Small job queue between the front and back parts of the console line reader.
// Depends on clr_pkg (job_type, qstat_type).
`timescale 1ns / 1ps

module clr_queue #(
   parameter int DEPTH = clr_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  clr_pkg::job_type  push_data,
   input  logic              pop,
   output clr_pkg::job_type  head,
   output clr_pkg::qstat_type stat
);
   import clr_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   job_type          slots_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      if (p == PtrW'(DEPTH - 1)) begin
         return '0;
      end
      return p + PtrW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head       = slots_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CntW'(DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

@@ design/clr_front.sv @@
// Front part: accepts requests, keeps the read state and config, classifies.
// Depends on clr_pkg; feeds jobs to clr_queue.
`timescale 1ns / 1ps

module clr_front #(
   parameter int ADDR_WIDTH = clr_pkg::AddrWidthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic [15:0]       req_descriptor,
   input  logic [31:0]       req_buf_addr,
   input  logic [31:0]       req_length,
   input  logic [7:0]        req_char_in,
   input  clr_pkg::qstat_type q_stat,
   output logic              push,
   output clr_pkg::job_type  push_data
);
   import clr_pkg::*;

   logic [31:0]           mem_low_ff, mem_high_ff;
   logic                  active_ff, active_in;
   logic [ADDR_WIDTH-1:0] base_ff, base_in;
   logic [31:0]           limit_ff, limit_in;
   logic [31:0]           count_ff, count_in;

   logic                  accept;
   logic [32:0]           end_sum;
   logic                  bad_addr;
   logic [ADDR_WIDTH-1:0] wr_sum;
   logic [31:0]           count_inc, count_dec;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;

   // 33-bit end of buffer, no wrap
   assign end_sum   = {1'b0, req_buf_addr} + {1'b0, req_length};
   assign bad_addr  = (req_buf_addr < mem_low_ff) || (end_sum > {1'b0, mem_high_ff});
   assign wr_sum    = base_ff + ADDR_WIDTH'(count_ff);
   assign count_inc = count_ff + 32'd1;
   assign count_dec = count_ff - 32'd1;

   always_comb begin
      active_in = active_ff;
      base_in   = base_ff;
      limit_in  = limit_ff;
      count_in  = count_ff;
      push      = 1'b0;
      push_data = '0;
      if (accept) begin
         if (req_type == ReqStart) begin
            active_in = 1'b0;
            push      = 1'b1;
            if (bad_addr) begin
               push_data.done_res = 1'b1;
               push_data.status   = StatBadAddr;
            end else if (req_descriptor != DescConsole) begin
               push_data.done_res = 1'b1;
               push_data.status   = StatBadDesc;
            end else begin
               active_in = 1'b1;
               base_in   = ADDR_WIDTH'(req_buf_addr);
               limit_in  = req_length;
               count_in  = '0;
            end
         end else if (active_ff) begin
            if (req_char_in == ChEot || count_ff >= limit_ff) begin
               active_in            = 1'b0;
               push                 = 1'b1;
               push_data.done_res   = 1'b1;
               push_data.byte_count = count_ff;
            end else if (req_char_in == ChNl || req_char_in == ChCr) begin
               active_in             = 1'b0;
               count_in              = count_inc;
               push                  = 1'b1;
               push_data.echo_valid  = 1'b1;
               push_data.echo_char   = ChNl;
               push_data.write_valid = 1'b1;
               push_data.write_addr  = 32'(wr_sum);
               push_data.write_data  = req_char_in;
               push_data.done_res    = 1'b1;
               push_data.byte_count  = count_inc;
            end else if (req_char_in == ChDel) begin
               // erase on an empty line is ignored
               if (count_ff != '0) begin
                  count_in             = count_dec;
                  push                 = 1'b1;
                  push_data.echo_valid = 1'b1;
                  push_data.echo_char  = ChBs;
                  push_data.byte_count = count_dec;
                  push_data.triple     = 1'b1;
               end
            end else begin
               count_in              = count_inc;
               push                  = 1'b1;
               push_data.echo_valid  = 1'b1;
               push_data.echo_char   = req_char_in;
               push_data.write_valid = 1'b1;
               push_data.write_addr  = 32'(wr_sum);
               push_data.write_data  = req_char_in;
               push_data.byte_count  = count_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_low_ff  <= MemLowReset;
         mem_high_ff <= MemHighReset;
         active_ff   <= 1'b0;
         base_ff     <= '0;
         limit_ff    <= '0;
         count_ff    <= '0;
      end else begin
         if (csr_write_en && csr_index == CsrMemLow) begin
            mem_low_ff <= csr_wdata;
         end
         if (csr_write_en && csr_index == CsrMemHigh) begin
            mem_high_ff <= csr_wdata;
         end
         active_ff <= active_in;
         base_ff   <= base_in;
         limit_ff  <= limit_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/clr_back.sv @@
// Back part: drains jobs, expands the erase triple, drives the response register.
// Depends on clr_pkg; reads the head of clr_queue.
`timescale 1ns / 1ps

module clr_back (
   input  logic               clock,
   input  logic               reset,
   input  clr_pkg::job_type   head,
   input  clr_pkg::qstat_type q_stat,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_echo_valid,
   output logic [7:0]         rsp_echo_char,
   output logic               rsp_write_valid,
   output logic [31:0]        rsp_write_addr,
   output logic [7:0]         rsp_write_data,
   output logic               rsp_done_res,
   output logic [31:0]        rsp_byte_count,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);
   import clr_pkg::*;

   localparam logic [1:0] PhFirst  = 2'd0;
   localparam logic [1:0] PhSecond = 2'd1;
   localparam logic [1:0] PhThird  = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic        valid_ff, valid_in;
   logic        take, final_one;
   logic        echo_valid_ff, write_valid_ff, done_ff, last_ff;
   logic [7:0]  echo_char_ff, write_data_ff;
   logic [31:0] write_addr_ff, count_ff;
   logic [1:0]  status_ff;

   assign take      = (!valid_ff || rsp_ready) && !q_stat.empty;
   assign final_one = !head.triple || phase_ff == PhThird;
   assign pop       = take && final_one;

   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         phase_in = final_one ? PhFirst : phase_ff + 2'd1;
      end
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhFirst;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         echo_valid_ff  <= head.echo_valid;
         echo_char_ff   <= (head.triple && phase_ff == PhSecond) ? ChSpace : head.echo_char;
         write_valid_ff <= head.write_valid;
         write_addr_ff  <= head.write_addr;
         write_data_ff  <= head.write_data;
         done_ff        <= head.done_res;
         count_ff       <= head.byte_count;
         status_ff      <= head.status;
         last_ff        <= final_one;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_echo_valid  = echo_valid_ff;
   assign rsp_echo_char   = echo_char_ff;
   assign rsp_write_valid = write_valid_ff;
   assign rsp_write_addr  = write_addr_ff;
   assign rsp_write_data  = write_data_ff;
   assign rsp_done_res    = done_ff;
   assign rsp_byte_count  = count_ff;
   assign rsp_status      = status_ff;
   assign rsp_last        = last_ff;

endmodule

@@ test/clr_checker.sv @@
// Scoreboard for the console line reader: snoops config writes and both channels.
// Predicts every response from accepted requests and compares field by field.
// Depends on clr_pkg for request kinds, characters, status codes and reset window.
`timescale 1ns / 1ps

module clr_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_type,
   input  logic [15:0] req_descriptor,
   input  logic [31:0] req_buf_addr,
   input  logic [31:0] req_length,
   input  logic [7:0]  req_char_in,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_echo_valid,
   input  logic [7:0]  rsp_echo_char,
   input  logic        rsp_write_valid,
   input  logic [31:0] rsp_write_addr,
   input  logic [7:0]  rsp_write_data,
   input  logic        rsp_done_res,
   input  logic [31:0] rsp_byte_count,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_last,
   output int unsigned failures,
   output int unsigned outstanding
);
   import clr_pkg::*;

   typedef struct packed {
      logic        echo_valid;
      logic [7:0]  echo_char;
      logic        write_valid;
      logic [31:0] write_addr;
      logic [7:0]  write_data;
      logic        done_res;
      logic [31:0] byte_count;
      logic [1:0]  status;
      logic        last;
   } line_result_type;

   line_result_type expected_q[$];
   logic [31:0]  window_low, window_high;
   logic         line_open;
   logic [31:0]  line_base, line_limit, line_count;
   int unsigned  fail_count = 0;

   function automatic line_result_type make_result(
      input logic ev, input logic [7:0] ec, input logic wv, input logic [31:0] wa,
      input logic [7:0] wd, input logic dn, input logic [31:0] bc, input logic [1:0] st,
      input logic ls);
      line_result_type r;
      r = '{ev, ec, wv, wa, wd, dn, bc, st, ls};
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      $display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
   endtask

   // expected responses of one accepted request
   task automatic predict_line(input logic kind, input logic [15:0] desc,
                               input logic [31:0] addr, input logic [31:0] len,
                               input logic [7:0] ch);
      logic [32:0] end_sum;
      end_sum = {1'b0, addr} + {1'b0, len};
      if (kind == ReqStart) begin
         line_open = 1'b0;
         if (addr < window_low || end_sum > {1'b0, window_high}) begin
            expected_q.push_back(make_result(0, 0, 0, 0, 0, 1, 0, StatBadAddr, 1));
         end else if (desc != DescConsole) begin
            expected_q.push_back(make_result(0, 0, 0, 0, 0, 1, 0, StatBadDesc, 1));
         end else begin
            line_open  = 1'b1;
            line_base  = addr;
            line_limit = len;
            line_count = '0;
            expected_q.push_back(make_result(0, 0, 0, 0, 0, 0, 0, StatOk, 1));
         end
      end else if (line_open) begin
         if (ch == ChEot || line_count >= line_limit) begin
            line_open = 1'b0;
            expected_q.push_back(make_result(0, 0, 0, 0, 0, 1, line_count, StatOk, 1));
         end else if (ch == ChNl || ch == ChCr) begin
            // echo is always a newline, but the byte stored is the one received
            expected_q.push_back(make_result(1, ChNl, 1, line_base + line_count, ch, 1,
                                             line_count + 1, StatOk, 1));
            line_count++;
            line_open = 1'b0;
         end else if (ch == ChDel) begin
            if (line_count != 0) begin
               line_count--;
               expected_q.push_back(make_result(1, ChBs, 0, 0, 0, 0, line_count, StatOk, 0));
               expected_q.push_back(make_result(1, ChSpace, 0, 0, 0, 0, line_count, StatOk, 0));
               expected_q.push_back(make_result(1, ChBs, 0, 0, 0, 0, line_count, StatOk, 1));
            end
         end else begin
            expected_q.push_back(make_result(1, ch, 1, line_base + line_count, ch, 0,
                                             line_count + 1, StatOk, 1));
            line_count++;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      line_result_type want;
      if (reset) begin
         expected_q.delete();
         window_low  = MemLowReset;
         window_high = MemHighReset;
         line_open   = 1'b0;
         line_base   = '0;
         line_limit  = '0;
         line_count  = '0;
      end else begin
         // responses first: one landing now belongs to an older request
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("response with nothing pending, byte_count", rsp_byte_count, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_echo_valid !== want.echo_valid)
                  report_mismatch("echo_valid", rsp_echo_valid, want.echo_valid);
               if (rsp_echo_char !== want.echo_char)
                  report_mismatch("echo_char", rsp_echo_char, want.echo_char);
               if (rsp_write_valid !== want.write_valid)
                  report_mismatch("write_valid", rsp_write_valid, want.write_valid);
               if (rsp_write_addr !== want.write_addr)
                  report_mismatch("write_addr", rsp_write_addr, want.write_addr);
               if (rsp_write_data !== want.write_data)
                  report_mismatch("write_data", rsp_write_data, want.write_data);
               if (rsp_done_res !== want.done_res)
                  report_mismatch("done_res", rsp_done_res, want.done_res);
               if (rsp_byte_count !== want.byte_count)
                  report_mismatch("byte_count", rsp_byte_count, want.byte_count);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end
         if (req_valid && req_ready)
            predict_line(req_type, req_descriptor, req_buf_addr, req_length, req_char_in);
         if (csr_write_en) begin
            if (csr_index == CsrMemLow)
               window_low = csr_wdata;
            else
               window_high = csr_wdata;
         end
      end
      failures    <= fail_count;
      outstanding <= expected_q.size();
   end

endmodule

@@ test/testbench.sv @@
// Top of the console line reader test: clock, reset, stimulus and verdict.
// Depends on clr_pkg, the console_line_reader RTL and clr_checker (scoreboard).
`timescale 1ns / 1ps

module testbench;
   import clr_pkg::*;

   localparam int CycleLimit = 300000;  // far above the slowest legal run
   localparam int DrainTail  = 8;       // covers the queue and response register plus margin
   localparam int HoldCycles = 60;      // long receiver hold, fills the internal queue

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic        csr_index;
   logic [31:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic        req_type;
   logic [15:0] req_descriptor;
   logic [31:0] req_buf_addr;
   logic [31:0] req_length;
   logic [7:0]  req_char_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_echo_valid;
   logic [7:0]  rsp_echo_char;
   logic        rsp_write_valid;
   logic [31:0] rsp_write_addr;
   logic [7:0]  rsp_write_data;
   logic        rsp_done_res;
   logic [31:0] rsp_byte_count;
   logic [1:0]  rsp_status;
   logic        rsp_last;

   int unsigned failures;
   int unsigned outstanding;    // responses still owed, from the scoreboard
   int unsigned cycle_count = 0;

   // our copy of the memory window, used to build legal starts
   logic [31:0] win_low  = MemLowReset;
   logic [31:0] win_high = MemHighReset;
   bit          calm      = 1'b0;  // no idling on either side
   bit          long_hold = 1'b0;  // asks the receiver for one long stall
   bit          line_live = 1'b0;  // rough guess whether a read is open

   console_line_reader dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_descriptor  (req_descriptor),
      .req_buf_addr    (req_buf_addr),
      .req_length      (req_length),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_echo_valid  (rsp_echo_valid),
      .rsp_echo_char   (rsp_echo_char),
      .rsp_write_valid (rsp_write_valid),
      .rsp_write_addr  (rsp_write_addr),
      .rsp_write_data  (rsp_write_data),
      .rsp_done_res    (rsp_done_res),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   clr_checker line_check (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_descriptor  (req_descriptor),
      .req_buf_addr    (req_buf_addr),
      .req_length      (req_length),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_echo_valid  (rsp_echo_valid),
      .rsp_echo_char   (rsp_echo_char),
      .rsp_write_valid (rsp_write_valid),
      .rsp_write_addr  (rsp_write_addr),
      .rsp_write_data  (rsp_write_data),
      .rsp_done_res    (rsp_done_res),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .failures        (failures),
      .outstanding     (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog: a hung handshake or a lost response ends here
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   // receiver: short random stalls, runs of ready, and one long hold on request
   initial begin : receiver
      int hold_left;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_ready <= 1'b0;
            for (hold_left = HoldCycles; hold_left > 0; hold_left--)
               @(posedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   // One request: optional gap first, then hold valid until the handshake.
   // Ready is sampled right after the edge, i.e. the value the block saw at it.
   task automatic send_req(input logic kind, input logic [15:0] desc,
                           input logic [31:0] addr, input logic [31:0] len,
                           input logic [7:0] ch);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_descriptor <= desc;
      req_buf_addr   <= addr;
      req_length     <= len;
      req_char_in    <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // character request; the unused start fields carry noise
   task automatic send_char(input logic [7:0] ch);
      send_req(ReqChar, 16'($urandom), $urandom, $urandom, ch);
   endtask

   // legal start inside the current window when it is not empty; shrinks the length if it cannot fit
   task automatic open_line(input logic [31:0] want_len, output logic [31:0] used_len,
                            output bit opened);
      logic [31:0] addr;
      used_len = want_len;
      opened   = (win_high >= win_low);
      if (!opened) begin
         addr = win_low;
      end else begin
         if (win_high - win_low < used_len)
            used_len = $urandom_range(0, win_high - win_low);
         addr = win_low + $urandom_range(0, win_high - win_low - used_len);
      end
      send_req(ReqStart, DescConsole, addr, used_len, 8'($urandom));
      line_live = opened;
   endtask

   // sender stops until every owed response has come back
   task automatic wait_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // full quiesce, including requests that owe nothing but may still be in flight
   task automatic settle();
      wait_responses();
      repeat (DrainTail) @(posedge clock);
   endtask

   task automatic set_window(input logic [31:0] lo, input logic [31:0] hi);
      settle();
      csr_write_en <= 1'b1;
      csr_index    <= CsrMemLow;
      csr_wdata    <= lo;
      @(posedge clock);
      csr_index    <= CsrMemHigh;
      csr_wdata    <= hi;
      @(posedge clock);
      csr_write_en <= 1'b0;
      win_low  = lo;
      win_high = hi;
   endtask

   function automatic logic [7:0] pick_char();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 20)
         return ChDel;
      if (roll < 30)
         return 8'($urandom_range(0, 255));
      return 8'($urandom_range(32, 126));
   endfunction

   // Random traffic: mostly complete lines with random content, some rejected
   // starts, abandoned lines and stray characters.
   task automatic run_random(input int unsigned n_items);
      int unsigned counted;
      int unsigned roll;
      int unsigned n_chars;
      int unsigned k;
      logic [31:0] len;
      logic [31:0] held;
      logic [31:0] addr;
      logic [7:0]  ch;
      bit          opened;
      counted = 0;
      while (counted < n_items) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            wait_responses();
         end else if (roll < 78) begin
            k = $urandom_range(0, 99);
            if (k < 70)
               len = $urandom_range(0, 8);
            else if (k < 85)
               len = $urandom_range(9, 40);
            else
               len = $urandom;
            open_line(len, len, opened);
            counted++;
            held    = '0;
            n_chars = $urandom_range(0, ((len > 12) ? 12 : len) + 3);
            for (k = 0; k < n_chars && opened; k++) begin
               ch = pick_char();
               send_char(ch);
               counted++;
               // track the line so nothing is sent into a closed read
               if (ch == ChEot || held >= len || ch == ChNl || ch == ChCr)
                  opened = 1'b0;
               else if (ch == ChDel)
                  held = (held != 0) ? held - 1 : held;
               else
                  held++;
            end
            if (opened) begin
               case ($urandom_range(0, 4))
                  0: ch = ChNl;
                  1: ch = ChCr;
                  2: ch = ChEot;
                  3: ch = pick_char();
                  default: ch = 8'h00;
               endcase
               if (ch != 8'h00) begin
                  send_char(ch);
                  counted++;
                  // a plain character or erase leaves the read open unless the line is already full
                  opened = !(ch == ChNl || ch == ChCr || ch == ChEot || held >= len);
               end
            end
            line_live = opened;
         end else if (roll < 90) begin
            // rejected or random starts; these also close any open read
            case ($urandom_range(0, 2))
               0: begin
                  open_line($urandom_range(0, 8), len, opened);
                  wait_responses();
                  addr = (win_high >= win_low) ? win_low : 32'h0;
                  send_req(ReqStart, 16'($urandom_range(1, 16'hFFFF)), addr, 32'h0,
                           8'($urandom));
                  counted++;
               end
               1: begin
                  addr = (win_low != 0) ? $urandom_range(0, win_low - 1) : $urandom;
                  send_req(ReqStart, DescConsole, addr, $urandom, 8'($urandom));
               end
               default: send_req(ReqStart, 16'($urandom), $urandom, $urandom, 8'($urandom));
            endcase
            counted++;
            line_live = 1'b0;
         end else if (!line_live) begin
            // stray character with no read open: ignored, not counted
            send_char(pick_char());
         end else begin
            send_char(ChEot);
            counted++;
            line_live = 1'b0;
         end
      end
   endtask

   initial begin : stimulus
      logic [31:0] len;
      bit          opened;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = CsrMemLow;
      csr_wdata      = '0;
      req_valid      = 1'b0;
      req_type       = ReqStart;
      req_descriptor = '0;
      req_buf_addr   = '0;
      req_length     = '0;
      req_char_in    = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, default window 0xA000_0000 .. 0xA3FF_FFFF
      send_req(ReqStart, DescConsole, 32'h0, 32'h0, 8'h00);              // below window
      send_req(ReqStart, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF); // end sum carries out
      send_req(ReqStart, DescConsole, 32'hA3FF_FFFF, 32'h1, 8'h00);      // one past the top
      send_req(ReqStart, 16'hFFFF, 32'hA000_0000, 32'h0, 8'h00);         // wrong descriptor
      send_char("a");                                                    // nothing open
      send_req(ReqStart, DescConsole, 32'hA3FF_FFFC, 32'h3, 8'h00);      // ends exactly at top
      send_char(ChDel);                                                  // erase on empty line
      send_char(8'h00);
      send_char(8'hFF);
      send_char(ChDel);                                                  // three echoes
      send_char("q");
      send_char("r");
      send_char("z");                                                    // line full: ends the read, not stored
      send_req(ReqStart, DescConsole, 32'hA000_0000, 32'd10, 8'h00);
      send_char("h");
      send_char(ChCr);                                                   // return stored as is
      send_req(ReqStart, DescConsole, 32'hA000_0000, 32'd10, 8'h00);
      send_char("i");
      send_char(ChNl);
      send_req(ReqStart, DescConsole, 32'hA100_0000, 32'd5, 8'h00);
      send_char("k");
      send_req(ReqStart, DescConsole, 32'hA200_0000, 32'd2, 8'h00);      // abandons the read
      send_char("m");
      send_char(ChEot);
      send_req(ReqStart, DescConsole, 32'hA000_0000, 32'd0, 8'h00);
      send_char(ChEot);                                                  // EOT wins at length 0
      send_req(ReqStart, DescConsole, 32'hA000_0000, 32'd0, 8'h00);
      send_char("x");

      // whole address space; the receiver holds off long enough to back up the block
      set_window(32'h0, 32'hFFFF_FFFF);
      long_hold = 1'b1;
      run_random(110);

      // degenerate windows: only a zero-length start at one address fits
      set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      open_line(32'h0, len, opened);
      send_char("w");
      run_random(15);
      set_window(32'h0, 32'h0);
      run_random(15);

      // random window, another long hold
      set_window($urandom_range(0, 32'hF000_0000), 32'h0);
      set_window(win_low, win_low + $urandom_range(64, 32'h0FFF_FFFF));
      long_hold = 1'b1;
      run_random(110);

      // last stretch back at the reset window, no idling on either side
      set_window(MemLowReset, MemHighReset);
      calm = 1'b1;
      run_random(80);

      settle();
      if (failures == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
